### hdl/tls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light sequencer package
// Shared types, register indexes, lamp codes and timing constants.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned PRESS_W     = 8;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Number of consecutive low button samples that count as one press.
  localparam logic [PRESS_W-1:0] DEBOUNCE_PASSES = 8'd200;

  // Blink half period is the shared phase duration divided by 2**BLINK_SHIFT
  // (divide by 8).
  localparam int unsigned BLINK_SHIFT = 3;

  localparam logic [DUR_W-1:0] RED_MS_RESET   = 16'd4000;
  localparam logic [DUR_W-1:0] PHASE_MS_RESET = 16'd1000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RED_MS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_MS = 1'b1;

  // Lamp drive vector: {red, yellow, green}.
  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b100;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b001;

  // Phase codes as seen on the result channel.
  localparam logic [1:0] CODE_RED    = 2'd0;
  localparam logic [1:0] CODE_GREEN  = 2'd1;
  localparam logic [1:0] CODE_BLINK  = 2'd2;
  localparam logic [1:0] CODE_YELLOW = 2'd3;

  typedef enum logic [3:0] {
    PH_RED    = 4'b0001,
    PH_GREEN  = 4'b0010,
    PH_BLINK  = 4'b0100,
    PH_YELLOW = 4'b1000
  } phase_t;

  typedef struct packed {
    logic button_level;
    logic tick;
  } item_t;

  typedef struct packed {
    logic       red_lamp;
    logic       yellow_lamp;
    logic       green_lamp;
    logic [1:0] phase;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0] red_ms;
    logic [DUR_W-1:0] phase_ms;
  } cfg_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_RED:    code = CODE_RED;
      PH_GREEN:  code = CODE_GREEN;
      PH_BLINK:  code = CODE_BLINK;
      PH_YELLOW: code = CODE_YELLOW;
      default:   code = CODE_RED;
    endcase
    return code;
  endfunction

endpackage

### hdl/tls_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light configuration registers
// Holds the red and other phase durations, written through a plain port.
// ----------------------------------------------------------------------------
module tls_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tls_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_ms   <= tls_pkg::RED_MS_RESET;
      cfg.phase_ms <= tls_pkg::PHASE_MS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tls_pkg::REG_RED_MS:   cfg.red_ms   <= cfg_data;
        tls_pkg::REG_PHASE_MS: cfg.phase_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hdl/tls_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light sequencer core
// Phase state, millisecond clock and debounce, advanced once per step.
// ----------------------------------------------------------------------------
module tls_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tls_pkg::item_t    item,
  input  tls_pkg::cfg_t     cfg,
  output tls_pkg::result_t  result_next
);

  tls_pkg::phase_t                   phase, phase_next;
  logic                              phase_entered, phase_entered_next;
  logic [tls_pkg::TIME_W-1:0]        now_ms, now_ms_next;
  logic [tls_pkg::TIME_W-1:0]        phase_start, phase_start_next;
  logic [tls_pkg::TIME_W-1:0]        phase_deadline, phase_deadline_next;
  logic [tls_pkg::TIME_W-1:0]        blink_last, blink_last_next;
  logic [tls_pkg::DUR_W-1:0]         red_duration, red_duration_next;
  logic                              shorten_request, shorten_request_next;
  logic [tls_pkg::PRESS_W-1:0]       press_count, press_count_next;
  logic [2:0]                        lamp, lamp_next;

  logic [tls_pkg::PRESS_W-1:0]       press_inc;
  logic                              press_hit;
  logic [tls_pkg::DUR_W-1:0]         red_dur_db;
  logic                              shorten_db;
  logic                              due;
  logic                              blink_due;
  logic [tls_pkg::TIME_W-1:0]        start_base;
  logic [tls_pkg::DUR_W-1:0]         dur_sel;
  logic [tls_pkg::TIME_W-1:0]        deadline_sum;
  logic [tls_pkg::TIME_W-1:0]        blink_span;
  logic [tls_pkg::DUR_W-1:0]         blink_period;

  // Millisecond clock first, then debounce, then the phase step.
  assign now_ms_next = now_ms + tls_pkg::TIME_W'(item.tick);

  assign press_inc  = item.button_level ? '0 : press_count + 1'b1;
  assign press_hit  = (press_inc >= tls_pkg::DEBOUNCE_PASSES);
  assign press_count_next = press_hit ? '0 : press_inc;
  assign red_dur_db = press_hit ? cfg.phase_ms : red_duration;
  assign shorten_db = press_hit | shorten_request;

  // One adder serves both a fresh entry and a shortened red.
  assign start_base   = phase_entered ? phase_start : now_ms_next;
  assign dur_sel      = (phase == tls_pkg::PH_RED) ? red_dur_db : cfg.phase_ms;
  assign deadline_sum = start_base + tls_pkg::TIME_W'(dur_sel);

  assign due          = (now_ms_next >= phase_deadline);
  assign blink_period = cfg.phase_ms >> tls_pkg::BLINK_SHIFT;
  assign blink_span   = now_ms_next - blink_last;
  assign blink_due    = (blink_span >= tls_pkg::TIME_W'(blink_period));

  always_comb begin
    phase_next           = phase;
    phase_entered_next   = phase_entered;
    phase_start_next     = phase_start;
    phase_deadline_next  = phase_deadline;
    blink_last_next      = blink_last;
    red_duration_next    = red_dur_db;
    shorten_request_next = shorten_db;
    lamp_next            = lamp;
    case (phase)
      tls_pkg::PH_RED: begin
        if (phase_entered) begin
          if (due) begin
            phase_next         = tls_pkg::PH_GREEN;
            phase_entered_next = 1'b0;
          end
          // A press during red shortens it; the deadline test above used the old value.
          if (shorten_db) begin
            shorten_request_next = 1'b0;
            phase_deadline_next  = deadline_sum;
            red_duration_next    = cfg.red_ms;
          end
        end else begin
          lamp_next            = tls_pkg::LAMP_RED;
          phase_start_next     = now_ms_next;
          phase_deadline_next  = deadline_sum;
          phase_entered_next   = 1'b1;
          shorten_request_next = 1'b0;
          red_duration_next    = cfg.red_ms;
        end
      end
      tls_pkg::PH_GREEN: begin
        if (phase_entered) begin
          if (due) begin
            phase_next         = tls_pkg::PH_BLINK;
            phase_entered_next = 1'b0;
          end
        end else begin
          lamp_next           = tls_pkg::LAMP_GREEN;
          phase_start_next    = now_ms_next;
          phase_deadline_next = deadline_sum;
          phase_entered_next  = 1'b1;
        end
      end
      tls_pkg::PH_BLINK: begin
        if (phase_entered) begin
          if (due) begin
            phase_next         = tls_pkg::PH_YELLOW;
            phase_entered_next = 1'b0;
          end
          if (blink_due) begin
            blink_last_next = now_ms_next;
            lamp_next       = lamp ^ tls_pkg::LAMP_GREEN;
          end
        end else begin
          lamp_next           = tls_pkg::LAMP_GREEN;
          phase_start_next    = now_ms_next;
          phase_deadline_next = deadline_sum;
          phase_entered_next  = 1'b1;
          blink_last_next     = now_ms_next;
        end
      end
      default: begin
        if (phase_entered) begin
          if (due) begin
            phase_next         = tls_pkg::PH_RED;
            phase_entered_next = 1'b0;
          end
        end else begin
          lamp_next           = tls_pkg::LAMP_YELLOW;
          phase_start_next    = now_ms_next;
          phase_deadline_next = deadline_sum;
          phase_entered_next  = 1'b1;
        end
      end
    endcase
  end

  assign result_next.red_lamp    = lamp_next[2];
  assign result_next.yellow_lamp = lamp_next[1];
  assign result_next.green_lamp  = lamp_next[0];
  assign result_next.phase       = tls_pkg::phase_code(phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tls_pkg::PH_RED;
      phase_entered   <= 1'b0;
      now_ms          <= '0;
      phase_start     <= '0;
      phase_deadline  <= '0;
      blink_last      <= '0;
      red_duration    <= tls_pkg::RED_MS_RESET;
      shorten_request <= 1'b0;
      press_count     <= '0;
      lamp            <= tls_pkg::LAMP_OFF;
    end else if (step) begin
      phase           <= phase_next;
      phase_entered   <= phase_entered_next;
      now_ms          <= now_ms_next;
      phase_start     <= phase_start_next;
      phase_deadline  <= phase_deadline_next;
      blink_last      <= blink_last_next;
      red_duration    <= red_duration_next;
      shorten_request <= shorten_request_next;
      press_count     <= press_count_next;
      lamp            <= lamp_next;
    end
  end

  // At most one lamp is ever driven.
  a_lamp_onehot0: assert property (@(posedge clk) disable iff (rst)
    $onehot0(lamp))
    else $error("more than one lamp driven");

  // Once red has been entered, only the red lamp is lit.
  a_red_lamp: assert property (@(posedge clk) disable iff (rst)
    (phase == tls_pkg::PH_RED && phase_entered) |-> (lamp == tls_pkg::LAMP_RED))
    else $error("red phase without red lamp");

  // The debounce counter is always cleared before it reaches the threshold.
  a_press_bound: assert property (@(posedge clk) disable iff (rst)
    press_count < tls_pkg::DEBOUNCE_PASSES)
    else $error("debounce counter out of range");

  // The millisecond clock only moves on a step, and then by at most one.
  a_clock_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(now_ms))
    else $error("clock advanced without a step");

endmodule

### hdl/traffic_light_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light sequencer
// Steps a red, green, blinking green, yellow cycle once per control pass,
// with a debounced button that shortens the red phase.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload          Direction
//   -------   -------------------------   --------------   ---------
//   item      item_valid / item_ready     item (item_t)    in
//   result    result_valid / result_ready result(result_t) out
//   config    cfg_we (no wait)            cfg_index/data   in
//
// One transaction on the item channel is one control pass and yields exactly
// one result transaction. The block sustains one item per clock cycle while
// the result channel is not stalled; an accepted item passes through the input
// register and then the result register, with the phase step in between.
// The synchronous reset restores the register defaults (red 4000 ms, other
// 1000 ms) and puts the sequencer in red, not yet entered, with all lamps off.
// When the result is stalled, the input register still takes one more item,
// and item_ready drops only once both registers are full.
// ----------------------------------------------------------------------------
module traffic_light_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  tls_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tls_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [tls_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tls_pkg::cfg_t     cfg;
  tls_pkg::item_t    item_q;
  logic              item_full;
  logic              step;
  tls_pkg::result_t  result_next;

  // The step runs whenever a held item exists and the result register can
  // take its outcome in the same edge.
  assign step       = item_full && (!result_valid || result_ready);
  assign item_ready = !item_full || step;

  tls_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tls_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item_q),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_full <= 1'b1;
    end else if (step) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  // A step never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !step)
    else $error("result overwritten while stalled");

  // Every step is followed by a valid result.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("step produced no result");

  // An accepted item is held in the input register on the next cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> item_full)
    else $error("accepted item lost");

endmodule

### tb/traffic_light_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traffic light sequencer testbench
// Drives control passes into the sequencer with random gaps and result
// stalls, predicts the lamp levels and phase of every pass, and compares
// each result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module traffic_light_sequencer_tb;

  // Predicts the lamp levels and phase after each accepted pass and holds
  // them until the matching result transaction arrives.
  class lamp_scoreboard;
    bit [tls_pkg::DUR_W-1:0]   red_ms;
    bit [tls_pkg::DUR_W-1:0]   phase_ms;
    bit [tls_pkg::DUR_W-1:0]   red_duration;
    bit [1:0]                  phase;
    bit                        entered;
    bit                        shorten_pending;
    bit [tls_pkg::TIME_W-1:0]  now_ms;
    bit [tls_pkg::TIME_W-1:0]  phase_start;
    bit [tls_pkg::TIME_W-1:0]  deadline;
    bit [tls_pkg::TIME_W-1:0]  blink_mark;
    bit [tls_pkg::PRESS_W-1:0] low_run;
    bit [2:0]                  lamps;
    tls_pkg::result_t          lamps_due[$];
    int unsigned               failures;
    int unsigned               passes;
    int unsigned               results;
    int unsigned               writes;
    int unsigned               shortenings;
    int unsigned               toggles;
    int unsigned               entries[4];

    function new();
      red_ms       = tls_pkg::RED_MS_RESET;
      phase_ms     = tls_pkg::PHASE_MS_RESET;
      red_duration = tls_pkg::RED_MS_RESET;
      phase        = tls_pkg::CODE_RED;
      lamps        = tls_pkg::LAMP_OFF;
    endfunction

    function void write_reg(logic [tls_pkg::CFG_INDEX_W-1:0] index,
                            logic [tls_pkg::CFG_DATA_W-1:0] value);
      writes++;
      if (index == tls_pkg::REG_RED_MS) begin
        red_ms = value;
      end else if (index == tls_pkg::REG_PHASE_MS) begin
        phase_ms = value;
      end
    endfunction

    function void start_phase(bit [2:0] lamp, bit [tls_pkg::DUR_W-1:0] span);
      lamps       = lamp;
      phase_start = now_ms;
      deadline    = now_ms + tls_pkg::TIME_W'(span);
      entered     = 1'b1;
      entries[phase]++;
    endfunction

    function void leave_when_due(bit [1:0] next);
      if (now_ms >= deadline) begin
        phase   = next;
        entered = 1'b0;
      end
    endfunction

    function void note_pass(tls_pkg::item_t it);
      tls_pkg::result_t          want;
      bit [tls_pkg::TIME_W-1:0]  half_period;
      passes++;
      now_ms = now_ms + tls_pkg::TIME_W'(it.tick);
      if (!it.button_level) begin
        low_run = low_run + 1'b1;
      end else begin
        low_run = '0;
      end
      if (low_run >= tls_pkg::DEBOUNCE_PASSES) begin
        low_run         = '0;
        red_duration    = phase_ms;
        shorten_pending = 1'b1;
        shortenings++;
      end
      case (phase)
        tls_pkg::CODE_RED: begin
          if (entered) begin
            leave_when_due(tls_pkg::CODE_GREEN);
            // A press during red pulls the deadline in from the original start.
            if (shorten_pending) begin
              shorten_pending = 1'b0;
              deadline        = phase_start + tls_pkg::TIME_W'(red_duration);
              red_duration    = red_ms;
            end
          end else begin
            start_phase(tls_pkg::LAMP_RED, red_duration);
            shorten_pending = 1'b0;
            red_duration    = red_ms;
          end
        end
        tls_pkg::CODE_GREEN: begin
          if (entered) begin
            leave_when_due(tls_pkg::CODE_BLINK);
          end else begin
            start_phase(tls_pkg::LAMP_GREEN, phase_ms);
          end
        end
        tls_pkg::CODE_BLINK: begin
          if (entered) begin
            leave_when_due(tls_pkg::CODE_YELLOW);
            half_period = tls_pkg::TIME_W'(phase_ms >> tls_pkg::BLINK_SHIFT);
            if (now_ms - blink_mark >= half_period) begin
              blink_mark = now_ms;
              lamps      = lamps ^ tls_pkg::LAMP_GREEN;
              toggles++;
            end
          end else begin
            start_phase(tls_pkg::LAMP_GREEN, phase_ms);
            blink_mark = now_ms;
          end
        end
        default: begin
          if (entered) begin
            leave_when_due(tls_pkg::CODE_RED);
          end else begin
            start_phase(tls_pkg::LAMP_YELLOW, phase_ms);
          end
        end
      endcase
      want.red_lamp    = lamps[2];
      want.yellow_lamp = lamps[1];
      want.green_lamp  = lamps[0];
      want.phase       = phase;
      lamps_due.push_back(want);
    endfunction

    function void compare(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        failures++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_lamps(tls_pkg::result_t got);
      tls_pkg::result_t want;
      results++;
      if (lamps_due.size() == 0) begin
        failures++;
        $error("result transaction %b arrived with no pass waiting", got);
        return;
      end
      want = lamps_due.pop_front();
      compare("red_lamp", 2'(want.red_lamp), 2'(got.red_lamp));
      compare("yellow_lamp", 2'(want.yellow_lamp), 2'(got.yellow_lamp));
      compare("green_lamp", 2'(want.green_lamp), 2'(got.green_lamp));
      compare("phase", want.phase, got.phase);
    endfunction

    function int unsigned pending();
      return lamps_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            item_valid;
  logic                            item_ready;
  tls_pkg::item_t                  item;
  logic                            result_valid;
  logic                            result_ready;
  tls_pkg::result_t                result;
  logic                            cfg_we;
  logic [tls_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tls_pkg::CFG_DATA_W-1:0]  cfg_data;

  lamp_scoreboard board;

  // Percentage of cycles in which the sender holds back and the receiver
  // stalls. It drops to zero for one whole random section.
  int unsigned idle_pct;
  int unsigned sent;

  traffic_light_sequencer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides its ready level at each falling edge, so the value
  // is stable by the rising edge at which a transaction may complete.
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Outputs are sampled at the rising edge, before the block's own updates
  // of that edge take effect.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      board.check_lamps(result);
    end
  end

  // Sends one control pass. Every task here starts and ends at a falling
  // edge. The valid level is only lowered for a gap, never between two
  // back-to-back transactions, so it never gets two updates in one step.
  task automatic send_pass(input bit level, input bit tick_in);
    tls_pkg::item_t it;
    it.button_level = level;
    it.tick         = tick_in;
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    do begin
      @(posedge clk);
    end while (!item_ready);
    board.note_pass(it);
    sent++;
    @(negedge clk);
  endtask

  // Holds the sender back until every predicted result has been consumed,
  // then waits out the given settle time with the block's pipeline empty.
  task automatic drain(input int unsigned settle);
    item_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  // Writes the red duration register and then the other phase duration
  // register. The write enable stays high across the two writes.
  task automatic load_times(input logic [tls_pkg::CFG_DATA_W-1:0] red_ms,
                            input logic [tls_pkg::CFG_DATA_W-1:0] phase_ms);
    cfg_we    <= 1'b1;
    cfg_index <= tls_pkg::REG_RED_MS;
    cfg_data  <= red_ms;
    @(posedge clk);
    board.write_reg(tls_pkg::REG_RED_MS, red_ms);
    @(negedge clk);
    cfg_index <= tls_pkg::REG_PHASE_MS;
    cfg_data  <= phase_ms;
    @(posedge clk);
    board.write_reg(tls_pkg::REG_PHASE_MS, phase_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned quota;
    int unsigned tick_pct;
    int unsigned low_pct;
    int unsigned run;
    int unsigned pick;
    bit          paused;
    board        = new();
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = tls_pkg::REG_RED_MS;
    cfg_data     = '0;
    idle_pct     = 25;
    sent         = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A few passes at the reset durations: the first one enters red and
    // lights the red lamp with a deadline far away.
    send_pass(1'b1, 1'b0);
    send_pass(1'b0, 1'b1);
    send_pass(1'b1, 1'b1);
    send_pass(1'b0, 1'b0);

    // Shortest durations. The pending red still runs on its old deadline,
    // so a held button has to shorten it. After that every phase lasts one
    // millisecond and the blink period is zero, so the green lamp toggles
    // on every blinking pass, including the one that leaves the phase.
    drain(4);
    load_times(16'd1, 16'd1);
    repeat (tls_pkg::DEBOUNCE_PASSES) send_pass(1'b0, 1'b0);
    repeat (14) send_pass(1'b1, 1'b1);
    send_pass(1'b1, 1'b0);
    send_pass(1'b0, 1'b1);

    // Random sections. Most traffic is held presses long enough to shorten red,
    // some just short of the debounce count, the rest a noisy button. Durations
    // are small so the lights keep cycling, except a maximal red every fourth section.
    for (int p = 0; p < 8; p++) begin
      drain(4);
      case (p % 4)
        0: load_times(16'($urandom_range(80, 20)), 16'($urandom_range(12, 1)));
        1: load_times(16'($urandom_range(10, 1)), 16'($urandom_range(40, 8)));
        2: load_times(16'($urandom_range(50, 1)), 16'($urandom_range(50, 1)));
        default: load_times(16'hFFFF, 16'($urandom_range(16, 1)));
      endcase
      idle_pct = (p == 5) ? 0 : 25;
      tick_pct = $urandom_range(90, 30);
      quota    = sent + 100;
      paused   = 1'b0;
      while (sent < quota) begin
        // Once per section the sender waits for the block to run dry.
        if (!paused && sent + 90 > quota) begin
          drain(0);
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          run     = $urandom_range(420, 200);
          low_pct = 100;
        end else if (pick < 55) begin
          run     = $urandom_range(199, 120);
          low_pct = 100;
        end else begin
          run     = $urandom_range(60, 10);
          low_pct = 30;
        end
        repeat (run) begin
          send_pass($urandom_range(99) >= low_pct, $urandom_range(99) < tick_pct);
        end
      end
    end

    // Longest durations last, since a phase entered now will not end soon.
    drain(4);
    load_times(16'hFFFF, 16'hFFFF);
    idle_pct = 25;
    repeat (100) send_pass(1'($urandom_range(1)), 1'($urandom_range(1)));

    drain(8);
    if (board.pending() != 0) begin
      board.failures++;
      $error("%0d predicted results never arrived", board.pending());
    end
    $display("Ran %0d passes, checked %0d results, %0d register writes, %0d red shortenings.",
             board.passes, board.results, board.writes, board.shortenings);
    $display("Phases entered red/green/blink/yellow: %0d/%0d/%0d/%0d, blink toggles: %0d.",
             board.entries[0], board.entries[1], board.entries[2], board.entries[3],
             board.toggles);
    if (board.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a block that stops accepting passes or producing results.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
hdl/tls_pkg.sv
hdl/tls_cfg_regs.sv
hdl/tls_core.sv
hdl/traffic_light_sequencer.sv
tb/traffic_light_sequencer_tb.sv
